// ----- hw/rtl/ebalu_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ebalu_pkg
// Shared types and constants for the 8-bit ALU with flags: beat structs,
// operation codes, flag bit positions and decimal adjust constants.
// ============================================================================
package ebalu_pkg;

    // Operation codes carried in the command field.
    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_ADC = 4'd1;
    localparam logic [3:0] CMD_SUB = 4'd2;
    localparam logic [3:0] CMD_SBC = 4'd3;
    localparam logic [3:0] CMD_AND = 4'd4;
    localparam logic [3:0] CMD_XOR = 4'd5;
    localparam logic [3:0] CMD_OR  = 4'd6;
    localparam logic [3:0] CMD_CP  = 4'd7;
    localparam logic [3:0] CMD_INC = 4'd8;
    localparam logic [3:0] CMD_DEC = 4'd9;
    localparam logic [3:0] CMD_DAA = 4'd10;
    localparam logic [3:0] CMD_CPL = 4'd11;
    localparam logic [3:0] CMD_SCF = 4'd12;
    localparam logic [3:0] CMD_CCF = 4'd13;

    // Flag bit positions in flags_in and flags_out.
    localparam int FLAG_Z_BIT = 3;
    localparam int FLAG_N_BIT = 2;
    localparam int FLAG_H_BIT = 1;
    localparam int FLAG_C_BIT = 0;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [3:0] DAA_NIBBLE_MAX = 4'd9;

    // One operation beat on the input channel.
    typedef struct packed {
        logic [3:0] command;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [3:0] flags_in;
    } cmd_beat_t;

    // One result beat on the output channel.
    typedef struct packed {
        logic [7:0] result;
        logic [3:0] flags_out;
    } res_beat_t;

endpackage

// ----- hw/rtl/ebalu_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ebalu_core
// Combinational datapath: computes the result byte and the new Z, N, H, C
// flags for one registered operation beat.
// ============================================================================
module ebalu_core
    import ebalu_pkg::*;
(
    input  cmd_beat_t op,
    output res_beat_t res
);

    logic       carry_in;
    logic       half_in;
    logic       add_c;
    logic       sub_c;
    logic [8:0] sum;
    logic [4:0] half_sum;
    logic [8:0] diff;
    logic [4:0] half_diff;
    logic [7:0] inc_val;
    logic [7:0] dec_val;
    logic       daa_hi;
    logic       daa_lo;
    logic [7:0] daa_add;
    logic [7:0] daa_sub;

    assign carry_in = op.flags_in[FLAG_C_BIT];
    assign half_in  = op.flags_in[FLAG_H_BIT];

    // Carry is only folded in for the with-carry forms.
    assign add_c = (op.command == CMD_ADC) & carry_in;
    assign sub_c = (op.command == CMD_SBC) & carry_in;

    // Adder and subtractor with a ninth bit for carry or borrow out.
    assign sum       = {1'b0, op.operand_a} + {1'b0, op.operand_b} + {8'd0, add_c};
    assign half_sum  = {1'b0, op.operand_a[3:0]} + {1'b0, op.operand_b[3:0]}
                     + {4'd0, add_c};
    assign diff      = {1'b0, op.operand_a} - {1'b0, op.operand_b} - {8'd0, sub_c};
    assign half_diff = {1'b0, op.operand_a[3:0]} - {1'b0, op.operand_b[3:0]}
                     - {4'd0, sub_c};

    assign inc_val = op.operand_a + 8'd1;
    assign dec_val = op.operand_a - 8'd1;

    // Decimal adjust corrections for the add and subtract cases.
    assign daa_hi  = carry_in | (op.operand_a > DAA_LIMIT);
    assign daa_lo  = half_in | (op.operand_a[3:0] > DAA_NIBBLE_MAX);
    assign daa_add = op.operand_a + (daa_hi ? DAA_HI_ADJ : 8'h00)
                   + (daa_lo ? DAA_LO_ADJ : 8'h00);
    assign daa_sub = op.operand_a - (carry_in ? DAA_HI_ADJ : 8'h00)
                   - (half_in ? DAA_LO_ADJ : 8'h00);

    // Operation decode and flag selection; flags are packed as Z, N, H, C.
    always_comb
    begin
        res.result    = op.operand_a;
        res.flags_out = op.flags_in;
        unique case (op.command)
            CMD_ADD, CMD_ADC:
            begin
                res.result    = sum[7:0];
                res.flags_out = {sum[7:0] == 8'h00, 1'b0, half_sum[4], sum[8]};
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                res.result    = (op.command == CMD_CP) ? op.operand_a : diff[7:0];
                res.flags_out = {diff[7:0] == 8'h00, 1'b1, half_diff[4], diff[8]};
            end
            CMD_AND:
            begin
                res.result    = op.operand_a & op.operand_b;
                res.flags_out = {(op.operand_a & op.operand_b) == 8'h00, 3'b010};
            end
            CMD_XOR:
            begin
                res.result    = op.operand_a ^ op.operand_b;
                res.flags_out = {(op.operand_a ^ op.operand_b) == 8'h00, 3'b000};
            end
            CMD_OR:
            begin
                res.result    = op.operand_a | op.operand_b;
                res.flags_out = {(op.operand_a | op.operand_b) == 8'h00, 3'b000};
            end
            CMD_INC:
            begin
                res.result    = inc_val;
                res.flags_out = {inc_val == 8'h00, 1'b0,
                                 op.operand_a[3:0] == 4'hF, carry_in};
            end
            CMD_DEC:
            begin
                res.result    = dec_val;
                res.flags_out = {dec_val == 8'h00, 1'b1,
                                 op.operand_a[3:0] == 4'h0, carry_in};
            end
            CMD_DAA:
            begin
                if (op.flags_in[FLAG_N_BIT])
                begin
                    res.result    = daa_sub;
                    res.flags_out = {daa_sub == 8'h00, 1'b1, 1'b0, carry_in};
                end
                else
                begin
                    res.result    = daa_add;
                    res.flags_out = {daa_add == 8'h00, 1'b0, 1'b0, daa_hi};
                end
            end
            CMD_CPL:
            begin
                res.result    = ~op.operand_a;
                res.flags_out = {op.flags_in[FLAG_Z_BIT], 1'b1, 1'b1, carry_in};
            end
            CMD_SCF:
            begin
                res.flags_out = {op.flags_in[FLAG_Z_BIT], 3'b001};
            end
            CMD_CCF:
            begin
                res.flags_out = {op.flags_in[FLAG_Z_BIT], 2'b00, ~carry_in};
            end
            default:
            begin
                // Unassigned codes pass the operand and flags through.
                res.result    = op.operand_a;
                res.flags_out = op.flags_in;
            end
        endcase
    end

endmodule

// ----- hw/rtl/eight_bit_alu_with_flags_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// eight_bit_alu_with_flags_unit
// 8-bit accumulator ALU with Z, N, H, C flags behind an input register and
// a result register, both with valid/ready handshakes.
// ============================================================================
// Usage:
// An operation beat (command, operand_a, operand_b, flags_in) enters on the
// in channel when in_valid and in_ready are both high. Each beat yields
// exactly one result beat (result, flags_out) on the out channel, taken when
// out_valid and out_ready are both high. Beats leave in arrival order.
// The beat is captured in the input register, goes through one pass of
// combinational ALU logic and lands in the result register, which raises
// out_valid; the result is taken from there once out_ready is high.
// Throughput is one beat per cycle while out_ready stays high; the two
// registers form a two-deep pipeline and each advances when the stage
// after it is empty or draining.
// When the receiver stalls, the result register holds its beat and the
// input register can still take one more beat; in_ready drops only when
// both registers are full and out_ready is low.
// Reset empties both registers; in_ready is high right after reset.
// ============================================================================
module eight_bit_alu_with_flags_unit
    import ebalu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cmd_beat_t in_beat,
    output logic      out_valid,
    input  logic      out_ready,
    output res_beat_t out_beat
);

    logic      op_valid_reg;
    cmd_beat_t op_reg;
    logic      res_valid_reg;
    res_beat_t res_reg;
    res_beat_t res_next;
    logic      res_load;
    logic      op_load;

    // Each register loads when it is empty or its content moves on.
    assign res_load = !res_valid_reg || out_ready;
    assign op_load  = !op_valid_reg || res_load;
    assign in_ready = op_load;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (op_load)
        begin
            op_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_load && in_valid)
        begin
            op_reg <= in_beat;
        end
    end

    // Single pass of ALU logic.
    ebalu_core u_core (
        .op  (op_reg),
        .res (res_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load && op_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_beat  = res_reg;

`ifndef SYNTHESIS
    // A beat accepted with the receiver ready reaches the result register and raises out_valid.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted beat did not reach the output in time");

    // A stalled output must not drop the beat waiting in the input register.
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid_reg && res_valid_reg && !out_ready) |=> op_valid_reg)
        else $error("pending beat lost during output stall");

    // A delivered result with nothing behind it must not be shown again.
    a_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_ready && !op_valid_reg) |=> !out_valid)
        else $error("result beat repeated");
`endif

endmodule
